### hw/rtl/lcdnw_pkg.sv
`timescale 1ns / 1ps

package lcdnw_pkg;

    // Kinds of input word.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_INIT  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_POWER_ON_WAIT       = 3'd0;
    localparam logic [2:0] REG_INIT_SECOND_WAIT    = 3'd1;
    localparam logic [2:0] REG_INIT_THIRD_WAIT     = 3'd2;
    localparam logic [2:0] REG_SETUP_WAIT          = 3'd3;
    localparam logic [2:0] REG_COMMAND_NIBBLE_WAIT = 3'd4;
    localparam logic [2:0] REG_DATA_NIBBLE_WAIT    = 3'd5;
    localparam logic [2:0] REG_ENABLE_PULSE_TICKS  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Nibbles of the power-on handshake.
    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

    // Init command indexes; FIRST and SECOND still have a command queued behind them.
    localparam logic [1:0] INIT_IDX_NONE   = 2'd0;
    localparam logic [1:0] INIT_IDX_FIRST  = 2'd1;
    localparam logic [1:0] INIT_IDX_SECOND = 2'd2;

    // Sequencer steps.
    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_POWER,
        STEP_P1,
        STEP_W2,
        STEP_P2,
        STEP_W3,
        STEP_P3,
        STEP_GAP,
        STEP_P4,
        STEP_SETUP,
        STEP_HI_PULSE,
        STEP_HI_WAIT,
        STEP_LO_PULSE,
        STEP_LO_WAIT
    } step_t;

    typedef enum logic [1:0] {
        STATUS_NONE,
        STATUS_ACCEPTED,
        STATUS_REFUSED
    } status_t;

    // Timing configuration as seen by the sequencer.
    typedef struct packed {
        logic [15:0] power_on_wait;
        logic [15:0] init_second_wait;
        logic [15:0] init_third_wait;
        logic [15:0] setup_wait;
        logic [15:0] command_nibble_wait;
        logic [15:0] data_nibble_wait;
        logic [7:0]  enable_pulse_ticks;
    } cfg_t;

    // One result word.
    typedef struct packed {
        logic       pin_rs;
        logic       pin_enable;
        logic [3:0] pin_data;
        logic       busy;
        status_t    status;
    } res_t;

    // Command bytes sent after the four-bit switch: function set, entry mode,
    // display on with cursor and blink.
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = 8'h28;
            2'd1:    cmd = 8'h06;
            2'd2:    cmd = 8'h0F;
            default: cmd = 8'h28;
        endcase
        return cmd;
    endfunction

endpackage

### hw/rtl/lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Word
// item      item_valid / item_stall      kind, byte_value, is_data
// result    result_valid / result_stall  pin_rs, pin_enable, pin_data, busy_res,
//                                        request_status
// cfg       cfg_we                       cfg_index, cfg_data
//
// One word is accepted per cycle; its result sits in the output register from
// the next cycle on. The sequencer state and the result register are the only
// pipeline stage. The input stalls only while a result waits and the output
// side stalls. Reset returns the sequencer to idle and the timing registers to
// their defaults; there is no clearing pass.

module lcd_nibble_write_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        kind,
    input  logic [7:0]                        byte_value,
    input  logic                              is_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              pin_rs,
    output logic                              pin_enable,
    output logic [3:0]                        pin_data,
    output logic                              busy_res,
    output logic [1:0]                        request_status,
    input  logic                              cfg_we,
    input  logic [lcdnw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import lcdnw_pkg::*;

    cfg_t cfg_reg;
    res_t res_next;
    res_t res_reg;
    logic result_valid_reg;
    logic accept;

    // Input is taken unless a finished word is held up at the output.
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    // Timing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_wait       <= 16'd15000;
            cfg_reg.init_second_wait    <= 16'd5000;
            cfg_reg.init_third_wait     <= 16'd100;
            cfg_reg.setup_wait          <= 16'd40;
            cfg_reg.command_nibble_wait <= 16'd5000;
            cfg_reg.data_nibble_wait    <= 16'd200;
            cfg_reg.enable_pulse_ticks  <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POWER_ON_WAIT:       cfg_reg.power_on_wait       <= cfg_data;
                REG_INIT_SECOND_WAIT:    cfg_reg.init_second_wait    <= cfg_data;
                REG_INIT_THIRD_WAIT:     cfg_reg.init_third_wait     <= cfg_data;
                REG_SETUP_WAIT:          cfg_reg.setup_wait          <= cfg_data;
                REG_COMMAND_NIBBLE_WAIT: cfg_reg.command_nibble_wait <= cfg_data;
                REG_DATA_NIBBLE_WAIT:    cfg_reg.data_nibble_wait    <= cfg_data;
                REG_ENABLE_PULSE_TICKS:  cfg_reg.enable_pulse_ticks  <= cfg_data[7:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    lcdnw_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept),
        .kind       (kind),
        .byte_value (byte_value),
        .is_data    (is_data),
        .cfg        (cfg_reg),
        .res        (res_next)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign pin_rs         = res_reg.pin_rs;
    assign pin_enable     = res_reg.pin_enable;
    assign pin_data       = res_reg.pin_data;
    assign busy_res       = res_reg.busy;
    assign request_status = res_reg.status;

endmodule

### hw/rtl/lcdnw_core.sv
`timescale 1ns / 1ps

module lcdnw_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [1:0]        kind,
    input  logic [7:0]        byte_value,
    input  logic              is_data,
    input  lcdnw_pkg::cfg_t   cfg,
    output lcdnw_pkg::res_t   res
);

    import lcdnw_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [EXT_W-1:0] CNT_MAX = EXT_W'({COUNT_WIDTH{1'b1}});

    step_t                  step_reg, step_next;
    logic [COUNT_WIDTH-1:0] wait_reg, wait_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   isdata_reg, isdata_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   rs_reg, rs_next;
    logic                   en_reg, en_next;
    logic [3:0]             data_reg, data_next;

    logic                   busy;
    logic [COUNT_WIDTH-1:0] wait_dec;
    logic                   load_en;
    logic [15:0]            load_val;
    logic                   finish;
    status_t                status;

    // A wait of zero counts as one tick; a wait beyond the counter saturates.
    function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [15:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext == '0)
        begin
            ext = EXT_W'(1);
        end
        if (ext > CNT_MAX)
        begin
            ext = CNT_MAX;
        end
        return COUNT_WIDTH'(ext);
    endfunction

    assign busy     = (step_reg != STEP_IDLE);
    assign wait_dec = wait_reg - COUNT_WIDTH'(wait_reg != '0);

    // Next state of the sequencer for the word at the input.
    always_comb
    begin
        step_next   = step_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        isdata_next = isdata_reg;
        idx_next    = idx_reg;
        rs_next     = rs_reg;
        en_next     = en_reg;
        data_next   = data_reg;
        status      = STATUS_NONE;
        load_en     = 1'b0;
        load_val    = '0;
        finish      = 1'b0;

        case (kind)
            KIND_TICK:
            begin
                if (busy)
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        case (step_reg)
                            STEP_POWER:
                            begin
                                rs_next   = 1'b0;
                                data_next = NIB_WAKE;
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_P1;
                            end
                            STEP_P1:
                            begin
                                en_next   = 1'b0;
                                load_en   = 1'b1;
                                load_val  = cfg.init_second_wait;
                                step_next = STEP_W2;
                            end
                            STEP_W2:
                            begin
                                data_next = NIB_WAKE;
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_P2;
                            end
                            STEP_P2:
                            begin
                                en_next   = 1'b0;
                                load_en   = 1'b1;
                                load_val  = cfg.init_third_wait;
                                step_next = STEP_W3;
                            end
                            STEP_W3:
                            begin
                                data_next = NIB_WAKE;
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_P3;
                            end
                            STEP_P3:
                            begin
                                en_next   = 1'b0;
                                load_en   = 1'b1;
                                load_val  = 16'd1;
                                step_next = STEP_GAP;
                            end
                            STEP_GAP:
                            begin
                                data_next = NIB_FOUR_BIT;
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_P4;
                            end
                            STEP_P4:
                            begin
                                // Bus is now four bits wide; queue the init commands.
                                en_next     = 1'b0;
                                byte_next   = init_cmd(INIT_IDX_NONE);
                                isdata_next = 1'b0;
                                idx_next    = INIT_IDX_FIRST;
                                rs_next     = 1'b0;
                                load_en     = 1'b1;
                                load_val    = cfg.setup_wait;
                                step_next   = STEP_SETUP;
                            end
                            STEP_SETUP:
                            begin
                                data_next = byte_reg[7:4];
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_HI_PULSE;
                            end
                            STEP_HI_PULSE:
                            begin
                                en_next   = 1'b0;
                                load_en   = 1'b1;
                                load_val  = isdata_reg ? cfg.data_nibble_wait
                                                       : cfg.command_nibble_wait;
                                step_next = STEP_HI_WAIT;
                            end
                            STEP_HI_WAIT:
                            begin
                                data_next = byte_reg[3:0];
                                en_next   = 1'b1;
                                load_en   = 1'b1;
                                load_val  = 16'(cfg.enable_pulse_ticks);
                                step_next = STEP_LO_PULSE;
                            end
                            STEP_LO_PULSE:
                            begin
                                en_next = 1'b0;
                                if (isdata_reg)
                                begin
                                    finish = 1'b1;
                                end
                                else
                                begin
                                    load_en   = 1'b1;
                                    load_val  = cfg.command_nibble_wait;
                                    step_next = STEP_LO_WAIT;
                                end
                            end
                            STEP_LO_WAIT:
                            begin
                                finish = 1'b1;
                            end
                            default:
                            begin
                                step_next = STEP_IDLE;
                                wait_next = '0;
                                idx_next  = INIT_IDX_NONE;
                            end
                        endcase
                    end
                end
            end
            KIND_INIT:
            begin
                if (busy)
                begin
                    status = STATUS_REFUSED;
                end
                else
                begin
                    status    = STATUS_ACCEPTED;
                    en_next   = 1'b0;
                    idx_next  = INIT_IDX_NONE;
                    load_en   = 1'b1;
                    load_val  = cfg.power_on_wait;
                    step_next = STEP_POWER;
                end
            end
            KIND_WRITE:
            begin
                if (busy)
                begin
                    status = STATUS_REFUSED;
                end
                else
                begin
                    status      = STATUS_ACCEPTED;
                    byte_next   = byte_value;
                    isdata_next = is_data;
                    idx_next    = INIT_IDX_NONE;
                    rs_next     = is_data;
                    load_en     = 1'b1;
                    load_val    = cfg.setup_wait;
                    step_next   = STEP_SETUP;
                end
            end
            default:
            begin
                status = STATUS_NONE;
            end
        endcase

        // End of one byte: start the next init command or go idle.
        if (finish)
        begin
            if (idx_reg == INIT_IDX_FIRST || idx_reg == INIT_IDX_SECOND)
            begin
                byte_next   = init_cmd(idx_reg);
                isdata_next = 1'b0;
                idx_next    = idx_reg + 2'd1;
                rs_next     = 1'b0;
                load_en     = 1'b1;
                load_val    = cfg.setup_wait;
                step_next   = STEP_SETUP;
            end
            else
            begin
                idx_next  = INIT_IDX_NONE;
                step_next = STEP_IDLE;
                wait_next = '0;
            end
        end

        if (load_en)
        begin
            wait_next = sat_load(load_val);
        end
    end

    // Sequencer state, advanced once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_IDLE;
            wait_reg   <= '0;
            byte_reg   <= '0;
            isdata_reg <= 1'b0;
            idx_reg    <= INIT_IDX_NONE;
            rs_reg     <= 1'b0;
            en_reg     <= 1'b0;
            data_reg   <= '0;
        end
        else if (go)
        begin
            step_reg   <= step_next;
            wait_reg   <= wait_next;
            byte_reg   <= byte_next;
            isdata_reg <= isdata_next;
            idx_reg    <= idx_next;
            rs_reg     <= rs_next;
            en_reg     <= en_next;
            data_reg   <= data_next;
        end
    end

    // Bus levels and status after this word.
    always_comb
    begin
        res.pin_rs     = rs_next;
        res.pin_enable = en_next;
        res.pin_data   = data_next;
        res.busy       = (step_next != STEP_IDLE);
        res.status     = status;
    end

    // The enable line is only ever high inside a running sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        en_reg |-> (step_reg != STEP_IDLE))
        else $error("enable high while idle");

    // A running sequence always has a wait pending; idle has none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_IDLE) == (wait_reg == '0))
        else $error("wait counter out of step with sequencer");

    // An init command index outside a sequence means a lost reset of the index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != INIT_IDX_NONE) |-> (step_reg != STEP_IDLE))
        else $error("init command index set while idle");

    // A refused request leaves the sequence exactly where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && (kind == KIND_INIT || kind == KIND_WRITE) && busy)
        |=> (step_reg == $past(step_reg) && wait_reg == $past(wait_reg)))
        else $error("refused request disturbed the sequence");

endmodule
